// ===== rtl/b256_pkg.sv =====
`timescale 1ns / 1ps

package b256_pkg;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       byte_valid;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic        last_word;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_OUTPUT
   } state_type;

   // What the message word reads see: raw block, padded last block,
   // first of two padding blocks, second block of zeros, end bit and length.
   typedef enum logic [1:0] {
      PAD_NONE,
      PAD_SINGLE,
      PAD_FIRST,
      PAD_SECOND
   } pad_type;

   localparam int ROUND_COUNT = 14;
   localparam int ROUND_W     = 4;
   localparam int SIGMA_ROWS  = 10;

   localparam logic [5:0]  FILL_LAST  = 6'd63;
   localparam logic [5:0]  MARK_POS   = 6'd55;
   localparam logic [5:0]  LEN_POS    = 6'd56;
   localparam logic [5:0]  PAD_LIMIT  = 6'd55;
   localparam logic [7:0]  PAD_START  = 8'h80;
   localparam logic [7:0]  PAD_END    = 8'h01;
   localparam logic [63:0] BLOCK_BITS = 64'd512;
   localparam logic [2:0]  OUT_LAST   = 3'd7;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] PI_WORDS [16] = '{
      32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344,
      32'hA4093822, 32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89,
      32'h452821E6, 32'h38D01377, 32'hBE5466CF, 32'h34E90C6C,
      32'hC0AC29B7, 32'hC97C50DD, 32'h3F84D5B5, 32'hB5470917
   };

   localparam logic [3:0] SIGMA [10][16] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
      '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
        4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
      '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
        4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
      '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
        4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
      '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
        4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
      '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
        4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
      '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
        4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
      '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
        4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
      '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
        4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
      '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
        4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
   };

endpackage

// ===== rtl/blake256_hash_engine_top.sv =====
`timescale 1ns / 1ps

// Channel   Ports                            Moves
// request   req_valid, req_stall, req_data   one message byte, byte flag, end flag
// result    rsp_valid, rsp_stall, rsp_data   one digest word, h0 first
//
// A byte that does not fill the block is stored while the engine stays idle.
// A full block runs one half G step per cycle, 16 per round, over 14 rounds.
// An ending request runs one or two padding blocks, then shows the eight words.
// req_stall is high while any block runs and while digest words are shown.
// rsp_stall holds the current word; reset is synchronous and restarts the message.

module blake256_hash_engine_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b256_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b256_pkg::rsp_type rsp_data
);
   import b256_pkg::*;

   state_type state_ff, state_in;
   pad_type   pad_ff, pad_in;
   logic      fin_ff, fin_in;
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [63:0] counter_ff, counter_in;
   logic [5:0]  fill_ff, fill_in;
   logic [31:0] msg_ff [16];
   logic [31:0] msg_in [16];
   logic [31:0] v_ff [4][4];
   logic [31:0] v_in [4][4];
   logic [31:0] v_step [4][4];
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [3:0]  sig_ff, sig_in;
   logic [2:0]  step_ff, step_in;
   logic        half_ff, half_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   logic        start;
   logic        start_skip;
   logic [5:0]  fin_fill;
   logic        diag;
   logic [3:0]  msg_idx;
   logic [3:0]  pi_idx;
   logic [31:0] mword;
   logic [31:0] ga, gb, gc, gd;
   logic [31:0] a1, b1, c1, d1, dx, bx;
   logic        comp_end;

   function automatic logic [31:0] pad_word(input logic [31:0] raw,
                                            input logic [3:0]  widx,
                                            input pad_type     mode,
                                            input logic [5:0]  f,
                                            input logic [63:0] len);
      logic [5:0] p;
      logic [7:0] b;
      logic [2:0] q;
      logic [1:0] lane;
      pad_word = '0;
      for (int l = 0; l < 4; l++) begin
         lane = 2'(l);
         p    = {widx, lane};
         q    = p[2:0];
         b    = raw[{~lane, 3'b000} +: 8];
         unique case (mode)
            PAD_NONE: begin
            end
            PAD_SECOND: begin
               b = '0;
               if (p == MARK_POS) b = PAD_END;
               if (p >= LEN_POS) b = len[{~q, 3'b000} +: 8];
            end
            PAD_FIRST, PAD_SINGLE: begin
               if (p == f) b = PAD_START;
               else if (p > f) b = '0;
               if (mode == PAD_SINGLE) begin
                  if (p == MARK_POS) b = b | PAD_END;
                  if (p >= LEN_POS) b = len[{~q, 3'b000} +: 8];
               end
            end
         endcase
         pad_word[{~lane, 3'b000} +: 8] = b;
      end
   endfunction

   // Columns work on position 0 of every row, diagonals on position r of row r;
   // the rows rotate left after each full G step.
   assign diag    = step_ff[2];
   assign msg_idx = SIGMA[sig_ff][{step_ff, half_ff}];
   assign pi_idx  = SIGMA[sig_ff][{step_ff, ~half_ff}];
   assign mword   = pad_word(msg_ff[msg_idx], msg_idx, pad_ff, fill_ff, counter_ff);

   assign ga = v_ff[0][0];
   assign gb = diag ? v_ff[1][1] : v_ff[1][0];
   assign gc = diag ? v_ff[2][2] : v_ff[2][0];
   assign gd = diag ? v_ff[3][3] : v_ff[3][0];

   assign a1 = ga + gb + (mword ^ PI_WORDS[pi_idx]);
   assign dx = gd ^ a1;
   assign d1 = half_ff ? {dx[7:0], dx[31:8]} : {dx[15:0], dx[31:16]};
   assign c1 = gc + d1;
   assign bx = gb ^ c1;
   assign b1 = half_ff ? {bx[6:0], bx[31:7]} : {bx[11:0], bx[31:12]};

   assign comp_end = (round_ff == ROUND_W'(ROUND_COUNT - 1)) && (step_ff == 3'd7) && half_ff;

   always_comb begin
      v_step = v_ff;
      v_step[0][0] = a1;
      if (diag) begin
         v_step[1][1] = b1;
         v_step[2][2] = c1;
         v_step[3][3] = d1;
      end else begin
         v_step[1][0] = b1;
         v_step[2][0] = c1;
         v_step[3][0] = d1;
      end
      if (half_ff) begin
         for (int r = 0; r < 4; r++) begin
            for (int p = 0; p < 4; p++) begin
               v_step[r][p] = (p == 3) ? v_ff[r][0] : v_ff[r][p + 1];
            end
         end
         v_step[0][3] = a1;
         if (diag) begin
            v_step[1][0] = b1;
            v_step[2][1] = c1;
            v_step[3][2] = d1;
         end else begin
            v_step[1][3] = b1;
            v_step[2][3] = c1;
            v_step[3][3] = d1;
         end
      end
   end

   assign fin_fill = fill_ff + 6'(req_data.byte_valid);

   always_comb begin
      state_in   = state_ff;
      pad_in     = pad_ff;
      fin_in     = fin_ff;
      chain_in   = chain_ff;
      counter_in = counter_ff;
      fill_in    = fill_ff;
      msg_in     = msg_ff;
      v_in       = v_ff;
      round_in   = round_ff;
      sig_in     = sig_ff;
      step_in    = step_ff;
      half_in    = half_ff;
      out_idx_in = out_idx_ff;
      start      = 1'b0;
      start_skip = 1'b0;
      req_stall  = (state_ff != ST_IDLE);
      rsp_valid  = (state_ff == ST_OUTPUT);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.byte_valid) begin
                  msg_in[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] = req_data.msg_byte;
               end
               if (req_data.byte_valid && (fill_ff == FILL_LAST)) begin
                  counter_in = counter_ff + BLOCK_BITS;
                  fill_in    = '0;
                  pad_in     = PAD_NONE;
                  fin_in     = req_data.last;
                  start      = 1'b1;
               end else if (req_data.last) begin
                  fill_in    = fin_fill;
                  counter_in = counter_ff + 64'({fin_fill, 3'b000});
                  pad_in     = (fin_fill <= PAD_LIMIT) ? PAD_SINGLE : PAD_FIRST;
                  start_skip = (fin_fill == '0);
                  start      = 1'b1;
               end else begin
                  fill_in = fin_fill;
               end
            end
         end
         ST_ROUND: begin
            v_in    = v_step;
            half_in = ~half_ff;
            if (half_ff) begin
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  round_in = round_ff + ROUND_W'(1);
                  sig_in   = (sig_ff == 4'(SIGMA_ROWS - 1)) ? '0 : sig_ff + 4'd1;
               end
            end
            if (comp_end) begin
               for (int i = 0; i < 8; i++) begin
                  chain_in[i] = chain_ff[i] ^ v_step[i / 4][i % 4]
                              ^ v_step[2 + i / 4][i % 4];
               end
               priority if (pad_ff == PAD_NONE && fin_ff) begin
                  // message ended on a block boundary: pad-only block, no counter
                  fin_in     = 1'b0;
                  pad_in     = PAD_SINGLE;
                  start_skip = 1'b1;
                  start      = 1'b1;
               end else if (pad_ff == PAD_FIRST) begin
                  pad_in     = PAD_SECOND;
                  start_skip = 1'b1;
                  start      = 1'b1;
               end else if (pad_ff == PAD_SINGLE || pad_ff == PAD_SECOND) begin
                  state_in   = ST_OUTPUT;
                  out_idx_in = '0;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OUTPUT: begin
            if (!rsp_stall) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == OUT_LAST) begin
                  // restart: new message
                  state_in   = ST_IDLE;
                  chain_in   = IV;
                  counter_in = '0;
                  fill_in    = '0;
                  pad_in     = PAD_NONE;
                  fin_in     = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (start) begin
         for (int p = 0; p < 4; p++) begin
            v_in[0][p] = chain_in[p];
            v_in[1][p] = chain_in[4 + p];
            v_in[2][p] = PI_WORDS[p];
            v_in[3][p] = PI_WORDS[4 + p];
            if (!start_skip) begin
               v_in[3][p] = PI_WORDS[4 + p] ^ ((p < 2) ? counter_in[31:0] : counter_in[63:32]);
            end
         end
         round_in = '0;
         sig_in   = '0;
         step_in  = '0;
         half_in  = 1'b0;
         state_in = ST_ROUND;
      end
   end

   assign rsp_data.digest_word = chain_ff[out_idx_ff];
   assign rsp_data.last_word   = (out_idx_ff == OUT_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pad_ff     <= PAD_NONE;
         fin_ff     <= 1'b0;
         chain_ff   <= IV;
         counter_ff <= '0;
         fill_ff    <= '0;
         round_ff   <= '0;
         sig_ff     <= '0;
         step_ff    <= '0;
         half_ff    <= 1'b0;
         out_idx_ff <= '0;
      end else begin
         state_ff   <= state_in;
         pad_ff     <= pad_in;
         fin_ff     <= fin_in;
         chain_ff   <= chain_in;
         counter_ff <= counter_in;
         fill_ff    <= fill_in;
         round_ff   <= round_in;
         sig_ff     <= sig_in;
         step_ff    <= step_in;
         half_ff    <= half_in;
         out_idx_ff <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      v_ff   <= v_in;
   end

endmodule
